### src/pws_pkg.sv
`default_nettype none
// ============================================================================
// pws_pkg
// Shared constants and types for the priority wake semaphore.
// ============================================================================
package pws_pkg;

    // Default sizing
    localparam int WAIT_SLOTS_DEF    = 16;
    localparam int ID_BITS_DEF       = 6;
    localparam int PRIORITY_BITS_DEF = 6;
    localparam int COUNT_BITS_DEF    = 16;

    // Fixed field widths on the ports
    localparam int FUNC_W    = 2;
    localparam int ID_W      = 6;
    localparam int PRI_W     = 6;
    localparam int WCOUNT_W  = 5;
    localparam int CFG_W     = 16;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 24;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_DOWN     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRY_DOWN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UP       = 2'd2;

    // Result item, granted in bit 0
    typedef struct packed {
        logic [PRI_W-1:0]    top_priority;
        logic [WCOUNT_W-1:0] waiter_count;
        logic [ID_W-1:0]     woken_id;
        logic                woken_valid;
        logic                overflow;
        logic                blocked;
        logic                granted;
    } result_t;

endpackage
`default_nettype wire

### src/pws_mem.sv
`default_nettype none
// ============================================================================
// pws_mem
// Simple dual-port wait table RAM, one write and one registered read port.
// ============================================================================
module pws_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 12,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### src/priority_wake_semaphore.sv
`default_nettype none
// ============================================================================
// priority_wake_semaphore
// Counting semaphore with a priority-ordered wait table held in RAM.
// ============================================================================
// A down, try-down or unused code holds the input while its result is
// registered; the result then moves to the output register once that
// register is free, and the input is ready again from that same edge. An up
// with N waiters in the table holds the input while the single RAM read
// port walks the table once to find the highest-priority (earliest on ties)
// waiter. It then walks it again to close the gap that waiter leaves and to
// find the new top priority. An up with an empty table skips both walks, like
// a down. One request is in flight at a time. The input is ready again as
// soon as the result moves to the output register, even if that register
// still waits on the sink. Writing the count register is only legal while
// idle; it does not touch the wait table.
module priority_wake_semaphore
    import pws_pkg::*;
#(
    parameter int WAIT_SLOTS    = WAIT_SLOTS_DEF,
    parameter int ID_BITS       = ID_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Count register load
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_W-1:0]      cfg_wr_data,    // initial_count

    // Requests
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // thread_id[5:0], priority_req[11:6]
    input  wire logic [FUNC_W-1:0]     s_axis_tuser,   // func[1:0]

    // Results
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [OUT_DATA_W-1:0] m_axis_tdata    // granted[0], blocked[1], overflow[2],
                                                       // woken_valid[3], woken_id[9:4],
                                                       // waiter_count[14:10], top_priority[20:15]
);

    localparam int IDX_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
    localparam int CNT_W = $clog2(WAIT_SLOTS + 1);
    localparam int ENT_W = ID_BITS + PRIORITY_BITS;
    localparam logic [CNT_W-1:0]      SLOTS_FULL = CNT_W'(WAIT_SLOTS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,     // find the waiter to wake
        ST_SHIFT,    // compact the table, find new top priority
        ST_RESULT
    } state_t;

    state_t                   state_reg, state_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;        // waiters, packed from slot 0
    logic [PRIORITY_BITS-1:0] top_reg, top_next;
    logic [CNT_W-1:0]         issue_reg, issue_next;      // next RAM address to read
    logic                     dvld_reg, dvld_next;        // RAM read data valid
    logic [CNT_W-1:0]         didx_reg, didx_next;        // slot of RAM read data
    logic [CNT_W-1:0]         best_idx_reg, best_idx_next;
    logic [PRIORITY_BITS-1:0] best_pri_reg, best_pri_next;
    logic [ID_BITS-1:0]       best_id_reg, best_id_next;
    logic [PRIORITY_BITS-1:0] max_reg, max_next;
    logic                     max_any_reg, max_any_next;
    result_t                  res_reg, res_next;
    result_t                  out_reg, out_next;
    logic                     tvalid_reg, tvalid_next;

    logic                     rd_en, wr_en;
    logic [IDX_W-1:0]         rd_addr, wr_addr;
    logic [ENT_W-1:0]         rd_data, wr_data;

    logic [FUNC_W-1:0]        req_func;
    logic [ID_BITS-1:0]       req_id;
    logic [PRIORITY_BITS-1:0] req_pri;
    logic [ID_BITS-1:0]       rd_id;
    logic [PRIORITY_BITS-1:0] rd_pri;
    logic                     in_xfer;
    logic                     last_data;
    logic [COUNT_BITS-1:0]    count_up;
    logic [CNT_W-1:0]         fill_dec;

    assign req_func = s_axis_tuser;
    assign req_id   = ID_BITS'(s_axis_tdata[5:0]);
    assign req_pri  = PRIORITY_BITS'(s_axis_tdata[11:6]);
    assign rd_id    = rd_data[ENT_W-1:PRIORITY_BITS];
    assign rd_pri   = rd_data[PRIORITY_BITS-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), out_reg};

    assign fill_dec  = fill_reg - 1'b1;
    assign last_data = dvld_reg && (didx_reg == fill_dec);
    assign count_up  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    pws_mem #(
        .DEPTH  (WAIT_SLOTS),
        .WIDTH  (ENT_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        fill_next     = fill_reg;
        top_next      = top_reg;
        issue_next    = issue_reg;
        dvld_next     = 1'b0;
        didx_next     = issue_reg;
        best_idx_next = best_idx_reg;
        best_pri_next = best_pri_reg;
        best_id_next  = best_id_reg;
        max_next      = max_reg;
        max_any_next  = max_any_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        tvalid_next   = tvalid_reg;

        rd_en   = 1'b0;
        rd_addr = issue_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = fill_reg[IDX_W-1:0];
        wr_data = {req_id, req_pri};

        if (tvalid_reg && m_axis_tready)
        begin
            tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_next   = '0;
                    state_next = ST_RESULT;
                    case (req_func)
                        FUNC_DOWN, FUNC_TRY_DOWN:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next       = count_reg - 1'b1;
                                res_next.granted = 1'b1;
                            end
                            else if (req_func == FUNC_DOWN)
                            begin
                                if (fill_reg == SLOTS_FULL)
                                begin
                                    res_next.overflow = 1'b1;
                                end
                                else
                                begin
                                    // append at the tail, arrival order kept
                                    wr_en            = 1'b1;
                                    fill_next        = fill_reg + 1'b1;
                                    res_next.blocked = 1'b1;
                                    if (fill_reg == '0 || req_pri > top_reg)
                                    begin
                                        top_next = req_pri;
                                    end
                                end
                            end
                        end
                        FUNC_UP:
                        begin
                            if (fill_reg != '0)
                            begin
                                issue_next = '0;
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                count_next = count_up;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.waiter_count = WCOUNT_W'(fill_next);
                    res_next.top_priority = PRI_W'(top_next);
                end
            end

            ST_SCAN:
            begin
                rd_en = (issue_reg < fill_reg);
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                dvld_next = rd_en;
                if (dvld_reg)
                begin
                    // strictly greater keeps the earliest on ties
                    if (didx_reg == '0 || rd_pri > best_pri_reg)
                    begin
                        best_idx_next = didx_reg;
                        best_pri_next = rd_pri;
                        best_id_next  = rd_id;
                    end
                end
                if (last_data)
                begin
                    issue_next   = '0;
                    max_any_next = 1'b0;
                    state_next   = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                rd_en = (issue_reg < fill_reg);
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                dvld_next = rd_en;
                if (dvld_reg && didx_reg != best_idx_reg)
                begin
                    if (!max_any_reg || rd_pri > max_reg)
                    begin
                        max_next = rd_pri;
                    end
                    max_any_next = 1'b1;
                    if (didx_reg > best_idx_reg)
                    begin
                        // slide one slot toward the head
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(didx_reg - 1'b1);
                        wr_data = rd_data;
                    end
                end
                if (last_data)
                begin
                    fill_next             = fill_dec;
                    top_next              = max_any_next ? max_next : '0;
                    count_next            = count_up;
                    res_next.woken_valid  = 1'b1;
                    res_next.woken_id     = ID_W'(best_id_reg);
                    res_next.waiter_count = WCOUNT_W'(fill_dec);
                    res_next.top_priority = PRI_W'(top_next);
                    state_next            = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (!tvalid_reg || m_axis_tready)
                begin
                    out_next    = res_reg;
                    tvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            count_next = COUNT_BITS'(cfg_wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            fill_reg     <= '0;
            top_reg      <= '0;
            issue_reg    <= '0;
            dvld_reg     <= 1'b0;
            didx_reg     <= '0;
            best_idx_reg <= '0;
            best_pri_reg <= '0;
            best_id_reg  <= '0;
            max_reg      <= '0;
            max_any_reg  <= 1'b0;
            res_reg      <= '0;
            out_reg      <= '0;
            tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            fill_reg     <= fill_next;
            top_reg      <= top_next;
            issue_reg    <= issue_next;
            dvld_reg     <= dvld_next;
            didx_reg     <= didx_next;
            best_idx_reg <= best_idx_next;
            best_pri_reg <= best_pri_next;
            best_id_reg  <= best_id_next;
            max_reg      <= max_next;
            max_any_reg  <= max_any_next;
            res_reg      <= res_next;
            out_reg      <= out_next;
            tvalid_reg   <= tvalid_next;
        end
    end

endmodule
`default_nettype wire
